/* src/bam_record_core_parser_core_assert.svh */
// Assertion macros shared by the record parser modules.
// Each macro expands to one labelled concurrent assertion, sampled on the
// rising clock edge and disabled while the synchronous reset is active.
`ifndef BAM_RECORD_CORE_PARSER_CORE_ASSERT_SVH
`define BAM_RECORD_CORE_PARSER_CORE_ASSERT_SVH

// Same-cycle implication.
`define BAM_RCP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// Next-cycle implication.
`define BAM_RCP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

/* src/bam_rcp_pkg.sv */
// ----------------------------------------------------------------------------
// bam_rcp_pkg
// Shared types and constants of the BAM alignment record parser.
// ----------------------------------------------------------------------------
package bam_rcp_pkg;

    localparam int unsigned CORE_BYTES = 32;

    typedef enum logic [2:0] {
        KIND_CORE  = 3'd0,
        KIND_CIGAR = 3'd1,
        KIND_DONE  = 3'd2,
        KIND_END   = 3'd3,
        KIND_ERROR = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] ref_id;
        logic [31:0] position;
        logic [15:0] bin;
        logic [7:0]  map_quality;
        logic [15:0] flag;
        logic [31:0] seq_length;
        logic [31:0] mate_ref_id;
        logic [31:0] mate_position;
        logic [31:0] insert_size;
        logic [27:0] cigar_length;
        logic [3:0]  cigar_op;
    } t_result;

    // One entry of the front-to-back queue: all results caused by one byte.
    // The second result never carries a payload.
    typedef struct packed {
        t_result first;
        logic    second_vld;
        t_kind   second_kind;
    } t_event;

endpackage

/* src/bam_record_core_parser_core.sv */
// ----------------------------------------------------------------------------
// bam_record_core_parser_core
// BAM alignment record parser: core fields and CIGAR operations.
// ----------------------------------------------------------------------------
// Feed the decompressed alignment stream one byte per request; every byte can
// be taken in consecutive cycles while full is low, since each one only
// advances the record counters and shifts into a 32-bit assembly word. A record
// gives one core result after its 32 core bytes, one result per CIGAR word, and
// a record done result once its last byte is in; a zero block length gives an
// end result, and a short block or a stream that stops mid-record gives an
// error result. The parser classifies each byte and drops the results it
// causes, at most two, as one event into a queue of P_QUEUE_DEPTH entries; the
// result stage drains that queue at one result per cycle while pop is high, so
// a byte whose event holds two results (a final CIGAR word with record done,
// say) takes the result slot for both in turn. A result passes through the
// queue and the result slot register before it appears. full is raised only
// while the queue holds P_QUEUE_DEPTH events; since a record yields far fewer
// results than bytes, with a queue of three or more entries the input stalls
// only when pop is held low. P_QUEUE_DEPTH may be set from 2 to 32; at 2, a run
// of stream-end bytes after a two-result byte can fill the queue even with pop
// held high. Fields not used by a result kind read as zero.
// ----------------------------------------------------------------------------
module bam_record_core_parser_core import bam_rcp_pkg::*; #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte side
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_data_byte,
    input  logic               i_stream_end,
    // result side
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         o_kind,
    output logic signed [31:0] o_ref_id,
    output logic signed [31:0] o_position,
    output logic [15:0]        o_bin,
    output logic [7:0]         o_map_quality,
    output logic [15:0]        o_flag,
    output logic [31:0]        o_seq_length,
    output logic signed [31:0] o_mate_ref_id,
    output logic signed [31:0] o_mate_position,
    output logic signed [31:0] o_insert_size,
    output logic [27:0]        o_cigar_length,
    output logic [3:0]         o_cigar_op
);

    logic    byte_accept;
    logic    evt_vld;
    t_event  evt;
    t_event  q_data;
    logic    q_empty;
    logic    q_pop;
    t_result result;

    // advance the parser only on an accepted request
    assign byte_accept = push && !full;

    bam_rcp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (byte_accept),
        .i_data_byte  (i_data_byte),
        .i_stream_end (i_stream_end),
        .o_evt_vld    (evt_vld),
        .o_evt        (evt)
    );

    // hold events here so that parser and result stage stall independently
    bam_rcp_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (evt_vld),
        .i_data  (evt),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    bam_rcp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (result)
    );

    assign o_kind          = result.kind;
    assign o_ref_id        = $signed(result.ref_id);
    assign o_position      = $signed(result.position);
    assign o_bin           = result.bin;
    assign o_map_quality   = result.map_quality;
    assign o_flag          = result.flag;
    assign o_seq_length    = result.seq_length;
    assign o_mate_ref_id   = $signed(result.mate_ref_id);
    assign o_mate_position = $signed(result.mate_position);
    assign o_insert_size   = $signed(result.insert_size);
    assign o_cigar_length  = result.cigar_length;
    assign o_cigar_op      = result.cigar_op;

endmodule

/* src/bam_rcp_front.sv */
// ----------------------------------------------------------------------------
// bam_rcp_front
// Byte parser: tracks the record layout and classifies each accepted byte
// into at most one queue event.
// ----------------------------------------------------------------------------
`include "bam_record_core_parser_core_assert.svh"

module bam_rcp_front import bam_rcp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_stream_end,
    output logic       o_evt_vld,
    output t_event     o_evt
);

    typedef enum logic [5:0] {
        PH_LEN     = 6'b000001,
        PH_CORE    = 6'b000010,
        PH_NAME    = 6'b000100,
        PH_CIGAR   = 6'b001000,
        PH_REST    = 6'b010000,
        PH_DISCARD = 6'b100000
    } t_phase;

    localparam logic [31:0] CORE_LEN = 32'(CORE_BYTES);

    t_phase      r_phase, n_phase;
    logic [31:0] r_byte_count, n_byte_count;
    logic [31:0] r_block_length, n_block_length;
    logic [31:0] r_assembly_word, n_assembly_word;
    logic [7:0]  r_name_length, n_name_length;
    logic [15:0] r_cigar_rem, n_cigar_rem;
    logic [31:0] r_core_word [8];

    logic [31:0] bc_inc;
    logic [31:0] name_end;
    logic [18:0] need;
    logic        core_we;
    logic        prim_vld;
    t_kind       prim_kind;
    logic        len_err;
    logic        mal_vld;
    logic        done_vld;
    logic        last_cond;
    logic        tail_err;

    assign n_assembly_word = {i_data_byte, r_assembly_word[31:8]};
    assign bc_inc          = r_byte_count + 32'd1;
    assign name_end        = CORE_LEN + {24'd0, r_name_length};
    assign need            = 19'(CORE_BYTES) + {11'd0, r_core_word[2][7:0]}
                           + {1'b0, r_core_word[3][15:0], 2'b00};

    always_comb begin
        n_phase        = r_phase;
        n_byte_count   = r_byte_count;
        n_block_length = r_block_length;
        n_name_length  = r_name_length;
        n_cigar_rem    = r_cigar_rem;
        core_we        = 1'b0;
        prim_vld       = 1'b0;
        prim_kind      = KIND_CORE;
        len_err        = 1'b0;
        mal_vld        = 1'b0;
        done_vld       = 1'b0;
        case (r_phase)
            PH_LEN: begin
                n_byte_count = bc_inc;
                if (r_byte_count[1:0] == 2'd3) begin
                    n_block_length = n_assembly_word;
                    n_byte_count   = '0;
                    if (n_assembly_word == '0) begin
                        prim_vld  = 1'b1;
                        prim_kind = KIND_END;
                    end else if (n_assembly_word < CORE_LEN) begin
                        prim_vld  = 1'b1;
                        prim_kind = KIND_ERROR;
                        len_err   = 1'b1;
                        n_phase   = PH_DISCARD;
                    end else begin
                        n_phase = PH_CORE;
                    end
                end
            end
            default: begin
                n_byte_count = bc_inc;
                case (r_phase)
                    PH_CORE: begin
                        core_we = (r_byte_count[1:0] == 2'd3);
                        if (r_byte_count[4:0] == 5'd31) begin
                            prim_vld      = 1'b1;
                            prim_kind     = KIND_CORE;
                            n_name_length = r_core_word[2][7:0];
                            n_cigar_rem   = r_core_word[3][15:0];
                            if ({13'd0, need} > r_block_length) begin
                                mal_vld = 1'b1;
                                n_phase = PH_DISCARD;
                            end else begin
                                n_phase = PH_NAME;
                                if (n_name_length == '0) begin
                                    n_phase = PH_CIGAR;
                                    if (n_cigar_rem == '0) begin
                                        n_phase = PH_REST;
                                    end
                                end
                            end
                        end
                    end
                    PH_NAME: begin
                        if (bc_inc == name_end) begin
                            n_phase = PH_CIGAR;
                            if (r_cigar_rem == '0) begin
                                n_phase = PH_REST;
                            end
                        end
                    end
                    PH_CIGAR: begin
                        // word boundary relative to the start of the CIGAR field
                        if ((r_byte_count[1:0] - r_name_length[1:0]) == 2'd3) begin
                            prim_vld    = 1'b1;
                            prim_kind   = KIND_CIGAR;
                            n_cigar_rem = r_cigar_rem - 16'd1;
                            if (n_cigar_rem == '0) begin
                                n_phase = PH_REST;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                if (bc_inc == r_block_length) begin
                    done_vld     = (n_phase != PH_DISCARD);
                    n_phase      = PH_LEN;
                    n_byte_count = '0;
                end
            end
        endcase
        last_cond = i_stream_end && !(n_phase == PH_LEN && n_byte_count == '0);
        if (last_cond) begin
            n_phase      = PH_LEN;
            n_byte_count = '0;
        end
        tail_err = mal_vld || (last_cond && !(len_err || mal_vld));
    end

    // Pack the results of this byte, oldest first.
    always_comb begin
        o_evt             = '0;
        o_evt.second_kind = KIND_ERROR;
        if (prim_vld) begin
            o_evt.first.kind = prim_kind;
            if (prim_kind == KIND_CORE) begin
                o_evt.first.ref_id        = r_core_word[0];
                o_evt.first.position      = r_core_word[1];
                o_evt.first.bin           = r_core_word[2][31:16];
                o_evt.first.map_quality   = r_core_word[2][15:8];
                o_evt.first.flag          = r_core_word[3][31:16];
                o_evt.first.seq_length    = r_core_word[4];
                o_evt.first.mate_ref_id   = r_core_word[5];
                o_evt.first.mate_position = r_core_word[6];
                o_evt.first.insert_size   = n_assembly_word;
            end else if (prim_kind == KIND_CIGAR) begin
                o_evt.first.cigar_length = n_assembly_word[31:4];
                o_evt.first.cigar_op     = n_assembly_word[3:0];
            end
            o_evt.second_vld  = done_vld || tail_err;
            o_evt.second_kind = done_vld ? KIND_DONE : KIND_ERROR;
        end else if (done_vld) begin
            o_evt.first.kind = KIND_DONE;
        end else begin
            o_evt.first.kind = KIND_ERROR;
        end
    end

    assign o_evt_vld = i_accept && (prim_vld || done_vld || tail_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_LEN;
            r_byte_count    <= '0;
            r_block_length  <= '0;
            r_assembly_word <= '0;
            r_name_length   <= '0;
            r_cigar_rem     <= '0;
        end else if (i_accept) begin
            r_phase         <= n_phase;
            r_byte_count    <= n_byte_count;
            r_block_length  <= n_block_length;
            r_assembly_word <= n_assembly_word;
            r_name_length   <= n_name_length;
            r_cigar_rem     <= n_cigar_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && core_we) begin
            r_core_word[r_byte_count[4:2]] <= n_assembly_word;
        end
    end

    `BAM_RCP_ASSERT_NXT(a_end_resyncs, i_clk, i_rst_n, i_accept && i_stream_end,
        r_phase == PH_LEN && r_byte_count == '0)
    `BAM_RCP_ASSERT_IMP(a_cigar_pending, i_clk, i_rst_n, r_phase == PH_CIGAR,
        r_cigar_rem != '0)

endmodule

/* src/bam_rcp_queue.sv */
// ----------------------------------------------------------------------------
// bam_rcp_queue
// Small register queue of parsed events between the parser and the
// result stage.
// ----------------------------------------------------------------------------
`include "bam_record_core_parser_core_assert.svh"

module bam_rcp_queue import bam_rcp_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_data,
    output logic   o_full,
    input  logic   i_pop,
    output t_event o_data,
    output logic   o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] LIMIT = CW'(DEPTH);

    t_event        r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == LIMIT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `BAM_RCP_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)

endmodule

/* src/bam_rcp_back.sv */
// ----------------------------------------------------------------------------
// bam_rcp_back
// Result stage: unpacks queued events into single results and holds the
// oldest one on the output until it is taken.
// ----------------------------------------------------------------------------
`include "bam_record_core_parser_core_assert.svh"

module bam_rcp_back import bam_rcp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_event  i_q_data,
    output logic    o_q_pop,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);

    t_result r_slot;
    logic    r_slot_vld;
    logic    r_second_vld;
    t_kind   r_second_kind;
    logic    take;
    logic    advance_second;
    t_result second_res;

    assign advance_second = r_slot_vld && i_pop && r_second_vld;
    assign take           = !r_slot_vld || (i_pop && !r_second_vld);
    assign o_q_pop        = take && !i_q_empty;
    assign o_empty        = !r_slot_vld;
    assign o_result       = r_slot;

    // second result of an event: kind only, no payload
    always_comb begin
        second_res      = '0;
        second_res.kind = r_second_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld   <= 1'b0;
            r_second_vld <= 1'b0;
        end else if (advance_second) begin
            r_second_vld <= 1'b0;
        end else if (o_q_pop) begin
            r_slot_vld   <= 1'b1;
            r_second_vld <= i_q_data.second_vld;
        end else if (r_slot_vld && i_pop) begin
            r_slot_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance_second) begin
            r_slot <= second_res;
        end else if (o_q_pop) begin
            r_slot        <= i_q_data.first;
            r_second_kind <= i_q_data.second_kind;
        end
    end

    `BAM_RCP_ASSERT_IMP(a_second_has_slot, i_clk, i_rst_n, r_second_vld, r_slot_vld)
    `BAM_RCP_ASSERT_IMP(a_second_kind, i_clk, i_rst_n, r_second_vld,
        r_second_kind == KIND_DONE || r_second_kind == KIND_ERROR)

endmodule

/* sim/tb_bam_record_core_parser_core.sv */
// ----------------------------------------------------------------------------
// tb_bam_record_core_parser_core
// Self-checking bench for the BAM record core parser. Byte streams are built
// from records with known core fields, name, CIGAR and tail lengths, plus
// short, overrun, zero-length, truncated and noise sequences. Every accepted
// byte is run through a cycle-free model of the parser, and the results it
// predicts are compared field by field with what the block pops out.
// ----------------------------------------------------------------------------
module tb_bam_record_core_parser_core import bam_rcp_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // Parser phases as the model tracks them.
    typedef enum logic [2:0] {
        PH_LENGTH,
        PH_CORE,
        PH_NAME,
        PH_CIGAR,
        PH_TAIL,
        PH_SKIP
    } t_phase;

    localparam int unsigned RANDOM_BYTES = 200;
    localparam int unsigned CALM_BYTES   = 60;
    localparam int unsigned PRINT_LIMIT  = 40;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [7:0]         i_data_byte;
    logic               i_stream_end;
    logic               empty;
    logic               pop = 1'b0;
    logic [2:0]         o_kind;
    logic signed [31:0] o_ref_id;
    logic signed [31:0] o_position;
    logic [15:0]        o_bin;
    logic [7:0]         o_map_quality;
    logic [15:0]        o_flag;
    logic [31:0]        o_seq_length;
    logic signed [31:0] o_mate_ref_id;
    logic signed [31:0] o_mate_position;
    logic signed [31:0] o_insert_size;
    logic [27:0]        o_cigar_length;
    logic [3:0]         o_cigar_op;

    // Model state of the parser.
    t_phase      ph;
    logic [31:0] cnt;
    logic [31:0] blk_len;
    logic [31:0] asm_word;
    logic [31:0] core_word [8];
    logic [7:0]  nm_len;
    logic [15:0] cig_left;

    // Results predicted but not yet popped, oldest first.
    t_result     pending_results [$];
    t_result     head;

    // Stimulus staging: core words of the next record and the bytes to send.
    logic [31:0] core_in [8];
    logic [7:0]  byte_q [$];

    bit          idle_on;
    int unsigned pop_hold = 0;
    int unsigned bytes_sent;
    int unsigned mismatches = 0;

    bam_record_core_parser_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_data_byte     (i_data_byte),
        .i_stream_end    (i_stream_end),
        .empty           (empty),
        .pop             (pop),
        .o_kind          (o_kind),
        .o_ref_id        (o_ref_id),
        .o_position      (o_position),
        .o_bin           (o_bin),
        .o_map_quality   (o_map_quality),
        .o_flag          (o_flag),
        .o_seq_length    (o_seq_length),
        .o_mate_ref_id   (o_mate_ref_id),
        .o_mate_position (o_mate_position),
        .o_insert_size   (o_insert_size),
        .o_cigar_length  (o_cigar_length),
        .o_cigar_op      (o_cigar_op)
    );

    // 20 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run with full idling on both sides.
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model of the parser
    // ------------------------------------------------------------------------

    function automatic t_result blank(input t_kind k);
        t_result r;
        r      = '0;
        r.kind = k;
        return r;
    endfunction

    // Append a predicted result behind those already waiting.
    function automatic void add_result(input t_result r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Append one byte to the staged stream.
    function automatic void stage_byte(input logic [7:0] b);
        byte_q.insert(byte_q.size(), b);
    endfunction

    // Move past an exhausted name and an empty CIGAR list.
    function automatic void advance_phase();
        if (ph == PH_NAME && cnt == CORE_BYTES + nm_len)
            ph = PH_CIGAR;
        if (ph == PH_CIGAR && cig_left == 16'd0)
            ph = PH_TAIL;
    endfunction

    // Advance the model by one accepted byte and queue the results it causes.
    function automatic void parse_byte(input logic [7:0] value, input logic last);
        logic        flagged;
        logic [31:0] pos;
        logic [31:0] rel;
        logic [31:0] need;
        t_result     r;
        flagged  = 1'b0;
        asm_word = {value, asm_word[31:8]};
        if (ph == PH_LENGTH) begin
            cnt = cnt + 1;
            if (cnt >= 4) begin
                blk_len = asm_word;
                cnt     = '0;
                if (blk_len == '0) begin
                    add_result(blank(KIND_END));
                end else if (blk_len < CORE_BYTES) begin
                    // Too short to hold the core: flag it and drop the block.
                    add_result(blank(KIND_ERROR));
                    flagged = 1'b1;
                    ph      = PH_SKIP;
                end else begin
                    ph = PH_CORE;
                end
            end
        end else begin
            pos = cnt;
            cnt = cnt + 1;
            if (ph == PH_CORE) begin
                if (pos[1:0] == 2'b11)
                    core_word[pos[4:2]] = asm_word;
                if (cnt == CORE_BYTES) begin
                    r               = blank(KIND_CORE);
                    r.ref_id        = core_word[0];
                    r.position      = core_word[1];
                    r.bin           = core_word[2][31:16];
                    r.map_quality   = core_word[2][15:8];
                    r.flag          = core_word[3][31:16];
                    r.seq_length    = core_word[4];
                    r.mate_ref_id   = core_word[5];
                    r.mate_position = core_word[6];
                    r.insert_size   = core_word[7];
                    add_result(r);
                    nm_len   = core_word[2][7:0];
                    cig_left = core_word[3][15:0];
                    need     = CORE_BYTES + nm_len + {cig_left, 2'b00};
                    if (need > blk_len) begin
                        // Name and CIGAR overrun the block: drop the remainder.
                        add_result(blank(KIND_ERROR));
                        flagged = 1'b1;
                        ph      = PH_SKIP;
                    end else begin
                        ph = PH_NAME;
                        advance_phase();
                    end
                end
            end else if (ph == PH_NAME) begin
                advance_phase();
            end else if (ph == PH_CIGAR) begin
                rel = pos - CORE_BYTES - nm_len;
                if (rel[1:0] == 2'b11) begin
                    r              = blank(KIND_CIGAR);
                    r.cigar_length = asm_word[31:4];
                    r.cigar_op     = asm_word[3:0];
                    add_result(r);
                    cig_left = cig_left - 16'd1;
                    advance_phase();
                end
            end
            if (ph != PH_LENGTH && cnt == blk_len) begin
                if (ph != PH_SKIP)
                    add_result(blank(KIND_DONE));
                ph  = PH_LENGTH;
                cnt = '0;
            end
        end
        // A stream that stops anywhere but a record boundary is an error, once.
        if (last && !(ph == PH_LENGTH && cnt == '0)) begin
            if (!flagged)
                add_result(blank(KIND_ERROR));
            ph  = PH_LENGTH;
            cnt = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result side: check each popped result and stall pop in random bursts
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h (kind %0d)",
                                      name, got, want, head.kind));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result of kind %0d", o_kind));
            end else begin
                head = pending_results.pop_front();
                check_field("kind",          32'(o_kind),      32'(head.kind));
                check_field("ref_id",        o_ref_id,        head.ref_id);
                check_field("position",      o_position,      head.position);
                check_field("bin",           32'(o_bin),       32'(head.bin));
                check_field("map_quality",   32'(o_map_quality), 32'(head.map_quality));
                check_field("flag",          32'(o_flag),      32'(head.flag));
                check_field("seq_length",    o_seq_length,    head.seq_length);
                check_field("mate_ref_id",   o_mate_ref_id,   head.mate_ref_id);
                check_field("mate_position", o_mate_position, head.mate_position);
                check_field("insert_size",   o_insert_size,   head.insert_size);
                check_field("cigar_length",  32'(o_cigar_length), 32'(head.cigar_length));
                check_field("cigar_op",      32'(o_cigar_op),  32'(head.cigar_op));
            end
        end
        // Now and then hold pop low for a random burst.
        if (pop_hold != 0) begin
            pop_hold = pop_hold - 1;
            pop <= 1'b0;
        end else if (idle_on && $urandom_range(0, 15) == 0) begin
            pop_hold = $urandom_range(1, 14) - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------------

    // Send one byte request, optionally after an idle burst, and feed the model
    // once the parser has taken it.
    task automatic send_byte(input logic [7:0] value, input logic last);
        if (idle_on && $urandom_range(0, 11) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_data_byte  <= value;
        i_stream_end <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        parse_byte(value, last);
        bytes_sent++;
    endtask

    function automatic void put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            stage_byte(w[8*i +: 8]);
    endfunction

    function automatic void random_core();
        for (int i = 0; i < 8; i++)
            core_in[i] = $urandom;
    endfunction

    // Stage one record: length word, then blk bytes of which the first 32 are
    // the core. Name, CIGAR and tail bytes are random, or all fill if fill >= 0.
    function automatic void put_record(input logic [7:0] name_len,
                                       input logic [15:0] n_cigar,
                                       input int unsigned blk, input int fill);
        core_in[2][7:0]  = name_len;
        core_in[3][15:0] = n_cigar;
        put_word(blk);
        for (int unsigned i = 0; i < blk; i++) begin
            if (i < CORE_BYTES)
                stage_byte(core_in[i >> 2][8*(i & 3) +: 8]);
            else if (fill < 0)
                stage_byte(8'($urandom));
            else
                stage_byte(fill[7:0]);
        end
    endfunction

    function automatic int unsigned full_len(input int unsigned name_len,
                                             input int unsigned n_cigar,
                                             input int unsigned n_tail);
        return CORE_BYTES + name_len + 4 * n_cigar + n_tail;
    endfunction

    // Send the staged bytes; mark the stream end at end_at and drop the rest.
    task automatic flush_stream(input int end_at);
        int last_idx;
        last_idx = (end_at >= 0) ? end_at : byte_q.size() - 1;
        for (int i = 0; i <= last_idx; i++)
            send_byte(byte_q[i], i == end_at);
        byte_q.delete();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Two zero lengths in a row; the second carries the stream end, which
    // falls on a record boundary and so raises no error.
    task automatic test_zero_length();
        put_word(32'd0);
        put_word(32'd0);
        flush_stream(7);
    endtask

    // Lengths too short for the core: flag, skip the block, resync.
    task automatic test_short_length();
        put_word(32'd1);
        stage_byte(8'hff);
        put_word(32'd31);
        for (int i = 0; i < 31; i++)
            stage_byte(8'($urandom));
        flush_stream(-1);
    endtask

    // Bare 32-byte records: core and record done come from the same byte.
    task automatic test_core_only();
        for (int i = 0; i < 8; i++)
            core_in[i] = 32'hffff_ffff;
        put_record(8'd0, 16'd0, CORE_BYTES, -1);
        for (int i = 0; i < 8; i++)
            core_in[i] = 32'h8000_0000;
        put_record(8'd0, 16'd0, CORE_BYTES, -1);
        for (int i = 0; i < 8; i++)
            core_in[i] = 32'h0000_0000;
        put_record(8'd0, 16'd0, CORE_BYTES, -1);
        flush_stream(-1);
    endtask

    // Name and CIGAR handling, including the longest name, all-ones and
    // all-zero CIGAR words, and a last CIGAR word that also ends the record.
    task automatic test_name_and_cigar();
        random_core();
        put_record(8'd255, 16'd1, full_len(255, 1, 0), -1);
        random_core();
        put_record(8'd3, 16'd2, full_len(3, 2, 0), 8'hff);
        random_core();
        put_record(8'd0, 16'd3, full_len(0, 3, 2), 8'h00);
        random_core();
        put_record(8'd1, 16'd0, full_len(1, 0, 5), -1);
        flush_stream(-1);
    endtask

    // Name plus CIGAR longer than the block: core, then error, no record done.
    task automatic test_length_overrun();
        random_core();
        put_record(8'd3, 16'hffff, 40, -1);
        random_core();
        put_record(8'd255, 16'd0, 100, -1);
        random_core();
        put_record(8'd2, 16'd2, full_len(2, 2, 0) - 1, -1);
        put_word(32'd0);
        flush_stream(-1);
    endtask

    // Stream end at every awkward point of a record.
    task automatic test_stream_end();
        int unsigned n;
        // inside the length field
        random_core();
        put_record(8'd2, 16'd1, full_len(2, 1, 0), -1);
        flush_stream(1);
        // on the last length byte of a valid length
        random_core();
        put_record(8'd0, 16'd1, full_len(0, 1, 0), -1);
        flush_stream(3);
        // inside the core
        random_core();
        put_record(8'd2, 16'd1, full_len(2, 1, 1), -1);
        flush_stream(10);
        // on the final byte of a complete record: no error
        random_core();
        put_record(8'd2, 16'd2, full_len(2, 2, 0), -1);
        flush_stream(byte_q.size() - 1);
        // on a short length itself: one error only
        put_word(32'd5);
        flush_stream(3);
        // in the skipped bytes of a short block
        put_word(32'd5);
        for (int i = 0; i < 5; i++)
            stage_byte(8'($urandom));
        flush_stream(5);
        // on a zero length: end only
        put_word(32'd0);
        flush_stream(3);
        // the largest length, cut short after a few CIGAR words
        random_core();
        core_in[2][7:0]  = 8'd4;
        core_in[3][15:0] = 16'd3;
        put_word(32'hffff_ffff);
        for (int i = 0; i < 8; i++)
            put_word(core_in[i]);
        n = 4 + 12 + 6;
        for (int unsigned i = 0; i < n; i++)
            stage_byte(8'($urandom));
        flush_stream(byte_q.size() - 1);
    endtask

    // Mostly well-formed records with random content; the rest short,
    // overrun, zero-length, truncated or plain noise.
    task automatic test_random_stream();
        int unsigned target;
        int unsigned pick;
        int unsigned n_name;
        int unsigned n_cig;
        int unsigned n_tail;
        int unsigned n;
        int          fill;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            // Drop all idling for the final stretch.
            idle_on = (bytes_sent + CALM_BYTES < target) && ($urandom_range(0, 3) != 0);
            pick    = $urandom_range(0, 99);
            random_core();
            n_name  = ($urandom_range(0, 29) == 0) ? 255 : $urandom_range(0, 6);
            n_cig   = $urandom_range(0, 4);
            n_tail  = $urandom_range(0, 3);
            fill    = ($urandom_range(0, 9) == 0) ? 8'hff : -1;
            if (pick < 70) begin
                put_record(8'(n_name), 16'(n_cig), full_len(n_name, n_cig, n_tail), fill);
                flush_stream(($urandom_range(0, 19) == 0) ? byte_q.size() - 1 : -1);
            end else if (pick < 80) begin
                n_cig = $urandom_range(1, 4);
                put_record(8'(n_name), 16'(n_cig),
                           full_len(n_name, n_cig, 0) - $urandom_range(1, 4), fill);
                flush_stream(-1);
            end else if (pick < 85) begin
                put_word(32'd0);
                flush_stream(-1);
            end else if (pick < 90) begin
                n = $urandom_range(1, CORE_BYTES - 1);
                put_word(n);
                for (int unsigned i = 0; i < n; i++)
                    stage_byte(8'($urandom));
                flush_stream(-1);
            end else if (pick < 95) begin
                put_record(8'(n_name), 16'(n_cig), full_len(n_name, n_cig, n_tail), fill);
                flush_stream($urandom_range(0, byte_q.size() - 2));
            end else begin
                // Noise: random bytes and end marks, always ending the stream
                // so the parser is back at a length field.
                n = $urandom_range(1, 8);
                for (int unsigned i = 0; i < n; i++)
                    send_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 3) == 0));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        // Initialise every input and the model while reset is held low.
        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_data_byte  = 8'd0;
        i_stream_end = 1'b0;
        idle_on      = 1'b1;
        bytes_sent   = 0;
        ph           = PH_LENGTH;
        cnt          = '0;
        blk_len      = '0;
        asm_word     = '0;
        nm_len       = '0;
        cig_left     = '0;
        for (int i = 0; i < 8; i++)
            core_word[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_length();
        test_short_length();
        test_core_only();
        test_name_and_cigar();
        test_length_overrun();
        test_stream_end();
        test_random_stream();

        // Drain: stop requesting, wait for every predicted result, then give
        // the pipeline room to show anything extra.
        idle_on = 1'b0;
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* bam_record_core_parser_core.f */
+incdir+src
src/bam_rcp_pkg.sv
src/bam_rcp_front.sv
src/bam_rcp_queue.sv
src/bam_rcp_back.sv
src/bam_record_core_parser_core.sv
sim/tb_bam_record_core_parser_core.sv
